// File: design/counting_semaphore_table_top_defines.svh
// Assertion macros shared by the semaphore table RTL.
// Each check is clocked on clk_i and is held off while rst_ni is low.
`ifndef COUNTING_SEMAPHORE_TABLE_TOP_DEFINES_SVH
`define COUNTING_SEMAPHORE_TABLE_TOP_DEFINES_SVH

// Same-cycle implication.
`define CSEM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/csem_pkg.sv
package csem_pkg;

  // Default table geometry
  localparam int NumSems   = 32;
  localparam int CountBits = 16;

  // Field widths of the request and response beats
  localparam int FuncW  = 2;
  localparam int IdW    = 6;
  localparam int InitW  = 17;
  localparam int StatW  = 3;

  typedef enum logic [FuncW-1:0] {
    FuncCreate = 2'd0,
    FuncWait   = 2'd1,
    FuncPost   = 2'd2,
    FuncRsvd   = 2'd3
  } func_e;

  typedef enum logic [StatW-1:0] {
    StOk       = 3'd0,
    StBadId    = 3'd1,
    StFull     = 3'd2,
    StNeg      = 3'd3,
    StBlock    = 3'd4,
    StOverflow = 3'd5
  } status_e;

endpackage

// File: design/csem_req_if.sv
interface csem_req_if;
  logic                         valid;
  logic                         ready;
  logic [csem_pkg::FuncW-1:0]   func;
  logic [csem_pkg::IdW-1:0]     sem_id;
  logic signed [csem_pkg::InitW-1:0] init_value;

  modport source (output valid, func, sem_id, init_value, input ready);
  modport sink   (input valid, func, sem_id, init_value, output ready);
endinterface

// File: design/csem_rsp_if.sv
interface csem_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [csem_pkg::StatW-1:0]   status;
  logic [csem_pkg::IdW-1:0]     result_id;
  logic                         wake;

  modport source (output valid, status, result_id, wake, input ready);
  modport sink   (input valid, status, result_id, wake, output ready);
endinterface

// File: design/counting_semaphore_table_top.sv
// A request beat accepted into the request register moves to the response register when
// the response slot is free or being drained. Throughput: one request per cycle while the
// response side drains; the table lookup, priority encode and count update all sit between
// the request register and the response register. Reset (rst_ni low, asynchronous) clears
// every used bit and count and drops both pipeline valids; req_i.ready is high once it lifts.
`include "counting_semaphore_table_top_defines.svh"

module counting_semaphore_table_top #(
  parameter int NUM_SEMS   = csem_pkg::NumSems,
  parameter int COUNT_BITS = csem_pkg::CountBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  csem_req_if.sink  req_i,
  csem_rsp_if.source rsp_o
);

  localparam int IdxW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

  // Request register
  logic                          s1_valid_q;
  logic [csem_pkg::FuncW-1:0]    s1_func_q;
  logic [csem_pkg::IdW-1:0]      s1_id_q;
  logic [csem_pkg::InitW-1:0]    s1_init_q;
  logic                          s1_fire;

  // Response register
  logic                          rsp_valid_q;
  csem_pkg::status_e             status_q, status_d;
  logic [csem_pkg::IdW-1:0]      result_id_q, result_id_d;
  logic                          wake_q, wake_d;

  // Semaphore table
  logic [NUM_SEMS-1:0]           used_q;
  logic [COUNT_BITS-1:0]         count_q [NUM_SEMS];

  // Decode signals
  logic [IdxW-1:0]               idx;
  logic [IdxW-1:0]               alloc_idx;
  logic                          free_found;
  logic                          id_ok;
  logic                          entry_used;
  logic [COUNT_BITS-1:0]         cur_count;
  logic [COUNT_BITS-1:0]         load_count;
  logic                          init_neg;
  logic                          init_fits;
  logic                          create_ok, wait_ok, post_ok;

  // Handshake: stage 1 moves when the response slot is free or being drained
  assign s1_fire     = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_func_q <= req_i.func;
      s1_id_q   <= req_i.sem_id;
      s1_init_q <= req_i.init_value;
    end
  end

  // Lowest free entry
  always_comb begin
    free_found = 1'b0;
    alloc_idx  = '0;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        alloc_idx  = IdxW'(i);
      end
    end
  end

  // Entry lookup
  assign idx        = s1_id_q[IdxW-1:0];
  assign id_ok      = (32'(s1_id_q) < NUM_SEMS);
  assign entry_used = id_ok && used_q[idx];
  assign cur_count  = count_q[idx];

  // Create value checks: sign bit, then range against the count width
  assign init_neg   = s1_init_q[csem_pkg::InitW-1];
  assign init_fits  = ((32'(s1_init_q[csem_pkg::InitW-2:0]) >> COUNT_BITS) == 32'd0);
  assign load_count = COUNT_BITS'(32'(s1_init_q[csem_pkg::InitW-2:0]));

  // Operation decode
  always_comb begin
    status_d    = csem_pkg::StBadId;
    result_id_d = s1_id_q;
    wake_d      = 1'b0;
    create_ok   = 1'b0;
    wait_ok     = 1'b0;
    post_ok     = 1'b0;
    unique case (csem_pkg::func_e'(s1_func_q))
      csem_pkg::FuncCreate: begin
        result_id_d = '0;
        priority if (init_neg) begin
          status_d = csem_pkg::StNeg;
        end else if (!init_fits) begin
          status_d = csem_pkg::StOverflow;
        end else if (!free_found) begin
          status_d = csem_pkg::StFull;
        end else begin
          status_d    = csem_pkg::StOk;
          result_id_d = csem_pkg::IdW'(alloc_idx);
          create_ok   = 1'b1;
        end
      end
      csem_pkg::FuncWait: begin
        priority if (!entry_used) begin
          status_d = csem_pkg::StBadId;
        end else if (cur_count == '0) begin
          status_d = csem_pkg::StBlock;
        end else begin
          status_d = csem_pkg::StOk;
          wait_ok  = 1'b1;
        end
      end
      csem_pkg::FuncPost: begin
        priority if (!entry_used) begin
          status_d = csem_pkg::StBadId;
        end else if (cur_count == '1) begin
          status_d = csem_pkg::StOverflow;
        end else begin
          status_d = csem_pkg::StOk;
          wake_d   = 1'b1;
          post_ok  = 1'b1;
        end
      end
      csem_pkg::FuncRsvd: begin
        status_d = csem_pkg::StBadId;
      end
      default: begin
        status_d = csem_pkg::StBadId;
      end
    endcase
  end

  // Table update, at most one entry per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      count_q <= '{default: '0};
    end else if (s1_fire) begin
      if (create_ok) begin
        used_q[alloc_idx]  <= 1'b1;
        count_q[alloc_idx] <= load_count;
      end
      if (wait_ok) begin
        count_q[idx] <= cur_count - COUNT_BITS'(1);
      end
      if (post_ok) begin
        count_q[idx] <= cur_count + COUNT_BITS'(1);
      end
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (s1_fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      status_q    <= status_d;
      result_id_q <= result_id_d;
      wake_q      <= wake_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.result_id = result_id_q;
  assign rsp_o.wake      = wake_q;

  // Checks
  `CSEM_ASSERT_NOW(a_wake_only_ok, rsp_valid_q && wake_q, status_q == csem_pkg::StOk, "wake on a failed post")
  `CSEM_ASSERT_NEXT(a_create_marks_used, s1_fire && create_ok, used_q[$past(alloc_idx)], "create left entry free")
  `CSEM_ASSERT_NEXT(a_used_monotonic, 1'b1, $countones(used_q) >= $past($countones(used_q)), "used entry was freed")
  `CSEM_ASSERT_NEXT(a_wait_decrements, s1_fire && wait_ok, count_q[$past(idx)] == $past(cur_count) - COUNT_BITS'(1), "wait did not decrement")

endmodule

// File: tb/tb_counting_semaphore_table_top.sv
`timescale 1ns / 100ps

module tb_counting_semaphore_table_top;
  import csem_pkg::*;

  localparam int CycLimit    = 200000;
  localparam int DrainSlack  = 8;
  localparam int RandomItems = 610;

  // Expected response beat
  typedef struct {
    status_e             status;
    logic [IdW-1:0]      id;
    logic                wake;
  } sem_rsp_t;

  logic clk;
  logic rst_n;

  csem_req_if req_if ();
  csem_rsp_if rsp_if ();

  counting_semaphore_table_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the semaphore table
  logic                 model_used [NumSems];
  logic [CountBits-1:0] model_count[NumSems];

  sem_rsp_t rsp_expect_q[$];

  int err_cnt;
  int req_sent;
  int rsp_seen;
  int wake_cnt;
  int st_seen[6];
  int cyc_cnt;

  // Receiver controls: random throttling and a one-shot long hold-off
  bit rx_throttle;
  int rx_hold_req;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    cyc_cnt = 0;
    forever begin
      @(posedge clk);
      cyc_cnt++;
      if (cyc_cnt > CycLimit) begin
        $display("%0t: watchdog expired with %0d responses outstanding", $time,
                 rsp_expect_q.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Response ready: random high/low runs, or a long hold-off when requested
  initial begin
    int hold_left;
    int run_left;
    bit run_level;
    hold_left = 0;
    run_left  = 0;
    run_level = 1'b1;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!rx_throttle) begin
        rsp_if.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_level = ($urandom_range(0, 2) != 0);
          run_left  = $urandom_range(1, 8);
        end
        run_left--;
        rsp_if.ready <= run_level;
      end
    end
  end

  // Next response for one request; updates the shadow table
  function automatic sem_rsp_t predict_sem_op(func_e op, logic [IdW-1:0] id,
                                              logic signed [InitW-1:0] val);
    sem_rsp_t    r;
    logic [InitW-1:0] raw;
    int unsigned cmax;
    raw    = val;
    cmax   = 32'hFFFF_FFFF >> (32 - CountBits);
    r.status = StBadId;
    r.id     = id;
    r.wake   = 1'b0;
    if (op == FuncCreate) begin
      r.id = '0;
      // negative check wins over full and over range
      if (raw[InitW-1]) begin
        r.status = StNeg;
      end else if (32'(raw) > cmax) begin
        r.status = StOverflow;
      end else begin
        r.status = StFull;
        for (int i = 0; i < NumSems; i++) begin
          if (!model_used[i]) begin
            model_used[i]  = 1'b1;
            model_count[i] = raw[CountBits-1:0];
            r.status       = StOk;
            r.id           = IdW'(i);
            break;
          end
        end
      end
    end else if (op != FuncRsvd && id < NumSems && model_used[id]) begin
      if (op == FuncWait) begin
        if (model_count[id] == '0) begin
          r.status = StBlock;
        end else begin
          model_count[id] = model_count[id] - 1'b1;
          r.status        = StOk;
        end
      end else begin
        // post saturates: overflow instead of wrap
        if (32'(model_count[id]) >= cmax) begin
          r.status = StOverflow;
        end else begin
          model_count[id] = model_count[id] + 1'b1;
          r.status        = StOk;
          r.wake          = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Drive one request beat and hold it until accepted
  task automatic send_req(func_e op, logic [IdW-1:0] id, logic signed [InitW-1:0] val);
    req_if.valid      <= 1'b1;
    req_if.func       <= op;
    req_if.sem_id     <= id;
    req_if.init_value <= val;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    rsp_expect_q.push_back(predict_sem_op(op, id, val));
    req_sent++;
  endtask

  // Drop valid with junk on the payload; n sets how long the idle lasts
  task automatic idle_cycles(int n);
    if (n > 0) begin
      req_if.valid      <= 1'b0;
      req_if.func       <= FuncWait;
      req_if.sem_id     <= IdW'($urandom_range(0, 63));
      req_if.init_value <= InitW'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    idle_cycles(1);
    while (rsp_expect_q.size() != 0) @(posedge clk);
  endtask

  // One random request; focus >= 0 steers wait/post toward one entry
  task automatic send_random_op(int focus);
    int r;
    logic [IdW-1:0] id;
    logic signed [InitW-1:0] v;
    r  = $urandom_range(0, 99);
    v  = InitW'($urandom_range(0, 131071));
    id = (focus >= 0) ? IdW'(focus) : IdW'($urandom_range(0, NumSems - 1));
    if (r < 40) begin
      send_req(FuncWait, id, v);
    end else if (r < 80) begin
      send_req(FuncPost, id, v);
    end else if (r < 88) begin
      send_req(FuncCreate, id, v);
    end else if (r < 94) begin
      id = IdW'($urandom_range(NumSems, 63));
      send_req(($urandom_range(0, 1) != 0) ? FuncWait : FuncPost, id, v);
    end else begin
      send_req(FuncRsvd, IdW'($urandom_range(0, 63)), v);
    end
  endtask

  // Corner cases on an empty table, back to back
  task automatic test_directed();
    rx_throttle = 1'b0;
    send_req(FuncWait, 6'd0, 17'sd0);         // unused entry
    send_req(FuncPost, 6'd63, 17'sd5);        // top id, out of range
    send_req(FuncCreate, 6'd0, 17'sh10000);   // most negative value
    send_req(FuncCreate, 6'd0, -17'sd1);
    send_req(FuncCreate, 6'd0, 17'sd65535);   // max count -> entry 0
    send_req(FuncPost, 6'd0, 17'sd0);         // post at max count
    send_req(FuncWait, 6'd0, 17'sd0);
    send_req(FuncPost, 6'd0, 17'sd0);         // back at max, wake
    send_req(FuncCreate, 6'd0, 17'sd0);       // zero count -> entry 1
    send_req(FuncWait, 6'd1, 17'sd0);         // would block
    send_req(FuncPost, 6'd1, 17'sd0);
    send_req(FuncWait, 6'd1, 17'sd0);
    send_req(FuncWait, 6'd1, 17'sd0);
    send_req(FuncRsvd, 6'd0, 17'sd0);         // reserved op on used entry
    send_req(FuncRsvd, 6'd63, -17'sd1);
    send_req(FuncWait, 6'(NumSems), 17'sd0);  // first invalid id
    send_req(FuncPost, 6'(NumSems - 1), 17'sd0);
    send_req(FuncPost, 6'd2, 17'sd0);
    wait_drain();
  endtask

  // Allocate every entry with a spread of start counts, then overfill
  task automatic test_table_full();
    logic signed [InitW-1:0] v;
    rx_throttle = 1'b1;
    for (int k = 0; k < NumSems; k++) begin
      case (k % 6)
        0: v = 17'sd0;
        1: v = 17'sd65535;
        2: v = 17'sd1;
        3: v = 17'sd65534;
        4: v = 17'sd32768;
        default: v = InitW'($urandom_range(0, 65535));
      endcase
      send_req(FuncCreate, IdW'($urandom_range(0, 63)), v);
      idle_cycles($urandom_range(0, 2));
    end
    send_req(FuncCreate, 6'd0, 17'sd7);
    send_req(FuncCreate, 6'd0, 17'sh10000);   // negative on a full table
    send_req(FuncCreate, 6'd63, 17'sd65535);
    wait_drain();
  endtask

  // Bursty traffic, mostly wait/post on live entries
  task automatic test_random_mix(int n_items);
    int sent;
    int burst;
    int focus;
    sent = 0;
    while (sent < n_items) begin
      rx_throttle = ($urandom_range(0, 4) != 0);
      burst = $urandom_range(1, 16);
      focus = ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, NumSems - 1)) : -1;
      for (int b = 0; b < burst; b++) begin
        send_random_op(focus);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  // Long response stall while requests keep coming
  task automatic test_backpressure();
    rx_throttle = 1'b1;
    rx_hold_req = 300;
    for (int k = 0; k < 40; k++) send_random_op(-1);
    wait_drain();
  endtask

  // Sender waits for a quiet block, then resumes
  task automatic test_drain_pause();
    rx_throttle = 1'b1;
    for (int k = 0; k < 10; k++) send_random_op(-1);
    wait_drain();
    repeat (DrainSlack) @(posedge clk);
    for (int k = 0; k < 20; k++) begin
      send_random_op(-1);
      idle_cycles($urandom_range(0, 3));
    end
    wait_drain();
  endtask

  // Response checker
  always @(posedge clk) begin : rsp_check
    sem_rsp_t e;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      rsp_seen++;
      if (rsp_expect_q.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual status %0d id %0d wake %0d",
                 $time, rsp_if.status, rsp_if.result_id, rsp_if.wake);
        err_cnt++;
      end else begin
        e = rsp_expect_q.pop_front();
        if (rsp_if.status !== e.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, e.status, rsp_if.status);
          err_cnt++;
        end
        if (rsp_if.result_id !== e.id) begin
          $display("%0t: result_id mismatch: expected %0d, actual %0d",
                   $time, e.id, rsp_if.result_id);
          err_cnt++;
        end
        if (rsp_if.wake !== e.wake) begin
          $display("%0t: wake mismatch: expected %0d, actual %0d",
                   $time, e.wake, rsp_if.wake);
          err_cnt++;
        end
        st_seen[e.status]++;
        if (e.wake) wake_cnt++;
      end
    end
  end

  // Main sequence
  initial begin
    err_cnt     = 0;
    req_sent    = 0;
    rsp_seen    = 0;
    wake_cnt    = 0;
    rx_throttle = 1'b0;
    rx_hold_req = 0;
    for (int i = 0; i < NumSems; i++) begin
      model_used[i]  = 1'b0;
      model_count[i] = '0;
    end
    for (int i = 0; i < 6; i++) st_seen[i] = 0;
    rst_n             <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.func       <= FuncCreate;
    req_if.sem_id     <= '0;
    req_if.init_value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_random_mix(RandomItems);
    test_backpressure();
    test_drain_pause();

    wait_drain();
    repeat (DrainSlack) @(posedge clk);

    $display("Run covered %0d requests, %0d responses, %0d wakes", req_sent, rsp_seen,
             wake_cnt);
    $display("Status mix ok/bad-id/full/neg/block/overflow: %0d/%0d/%0d/%0d/%0d/%0d",
             st_seen[StOk], st_seen[StBadId], st_seen[StFull], st_seen[StNeg],
             st_seen[StBlock], st_seen[StOverflow]);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
